[design/lifo_memory_budget_admission_macros.svh]
// assertion macros shared by the checker of the lifo budget admission block
// depends on nothing; take it in with a plain include
`ifndef LIFO_MEMORY_BUDGET_ADMISSION_MACROS_SVH
`define LIFO_MEMORY_BUDGET_ADMISSION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LMBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmba check failed");

// antecedent implies consequent in the next cycle
`define LMBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmba check failed");

`endif

[design/lmba_pkg.sv]
// types and constants of the lifo budget admission block
// used by the stack cell, the top level and the checker; depends on nothing
package lmba_pkg;

   localparam int unsigned ID_W   = 8;
   localparam int unsigned SIZE_W = 16;
   localparam int unsigned OUT_CNT_W = 5;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'd200;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // shift command broadcast along the chain
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   typedef enum logic [1:0] {
      ST_ADMITTED  = 2'd0,
      ST_ALREADY   = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CHECK,
      S_EVICT,
      S_RESPOND
   } state_type;

endpackage

[design/lmba_cell.sv]
// one slot of the shifting stack: holds an entry, shifts on push or pop,
// and passes the id-match flag on to the next slot; depends on lmba_pkg
module lmba_cell (
   input  logic                               clock,
   input  lmba_pkg::shift_type                shift,
   input  logic                               occupied,
   input  logic [lmba_pkg::ID_W-1:0]          probe_id,
   input  lmba_pkg::entry_type                above,
   input  lmba_pkg::entry_type                below,
   input  logic                               hit_up,
   output lmba_pkg::entry_type                entry,
   output logic                               hit_out
);

   lmba_pkg::entry_type entry_ff, entry_in;
   logic                hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = above;
      end else if (shift.pop) begin
         entry_in = below;
      end
      hit_in = hit_up | (occupied & (entry_ff.id == probe_id));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry   = entry_ff;
   assign hit_out = hit_ff;

endmodule

[design/lifo_memory_budget_admission.sv]
// Admission of open requests against a memory budget, kept as a LIFO stack
// held in a chain of STACK_DEPTH slots, top of stack in the first slot. For
// an admitted or stack-full request the id match flag ripples through the
// chain one slot a cycle, then the request is decided, each eviction pops
// one slot a cycle, then the entry is pushed or the request rejected, and
// the result register is loaded once the previous result has been taken.
// An already-open or too-large request is rejected when it is decided. One
// request is in flight at a time; after the result is loaded the block
// returns to idle, where the next request may be accepted while the last
// result still waits. capacity is written through csr_wr_en/csr_wr_data.
module lifo_memory_budget_admission #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lmba_pkg::ID_W-1:0]             req_app_id,
   input  logic [lmba_pkg::SIZE_W-1:0]           req_app_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [lmba_pkg::OUT_CNT_W-1:0]        rsp_evicted_count,
   output logic [lmba_pkg::SIZE_W-1:0]           rsp_used_after,
   output logic [lmba_pkg::SIZE_W-1:0]           rsp_available_after,
   output logic [lmba_pkg::OUT_CNT_W-1:0]        rsp_entries_after,
   input  logic                                  csr_wr_en,
   input  logic [lmba_pkg::SIZE_W-1:0]           csr_wr_data
);

   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned SRCH_W = $clog2(STACK_DEPTH);

   lmba_pkg::state_type  state_ff, state_in;
   logic [SRCH_W-1:0]    wait_ff, wait_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     evicted_ff, evicted_in;
   logic [lmba_pkg::SIZE_W-1:0] used_ff, used_in;
   logic [lmba_pkg::SIZE_W-1:0] cap_ff;
   logic [lmba_pkg::ID_W-1:0]   id_ff, id_in;
   logic [lmba_pkg::SIZE_W-1:0] size_ff, size_in;
   lmba_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 load_rsp;
   lmba_pkg::shift_type  shift;

   logic [1:0]                   rsp_status_ff;
   logic [lmba_pkg::OUT_CNT_W-1:0] rsp_evicted_ff, rsp_entries_ff;
   logic [lmba_pkg::SIZE_W-1:0]  rsp_used_ff, rsp_avail_ff;

   lmba_pkg::entry_type cell_entry [STACK_DEPTH];
   logic                cell_hit   [STACK_DEPTH];
   lmba_pkg::entry_type new_entry;

   logic [lmba_pkg::SIZE_W:0]   demand;
   logic [lmba_pkg::SIZE_W-1:0] top_size, used_base;
   logic [31:0]                 count_wide, evicted_wide;

   assign new_entry = '{id: id_ff, size: size_ff};
   assign top_size  = cell_entry[0].size;
   assign demand    = {1'b0, used_ff} + {1'b0, size_ff};
   assign used_base = (count_ff == '0) ? '0 : used_ff;

   // the chain of stack slots
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      lmba_pkg::entry_type above_w, below_w;
      logic                hit_w;
      if (i == 0) begin : g_first
         assign above_w = new_entry;
         assign hit_w   = 1'b0;
      end else begin : g_rest
         assign above_w = cell_entry[i-1];
         assign hit_w   = cell_hit[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below_w = '0;
      end else begin : g_inner
         assign below_w = cell_entry[i+1];
      end
      lmba_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .occupied (CNT_W'(i) < count_ff),
         .probe_id (id_ff),
         .above    (above_w),
         .below    (below_w),
         .hit_up   (hit_w),
         .entry    (cell_entry[i]),
         .hit_out  (cell_hit[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      evicted_in   = evicted_ff;
      used_in      = used_ff;
      id_in        = id_ff;
      size_in      = size_ff;
      status_in    = status_ff;
      shift        = '{push: 1'b0, pop: 1'b0};
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         lmba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               id_in      = req_app_id;
               size_in    = req_app_size;
               wait_in    = '0;
               evicted_in = '0;
               state_in   = lmba_pkg::S_SEARCH;
            end
         end
         lmba_pkg::S_SEARCH: begin
            // wait while the match flag ripples through the slots to the end of the chain
            if (wait_ff == SRCH_W'(STACK_DEPTH - 1)) begin
               state_in = lmba_pkg::S_CHECK;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         lmba_pkg::S_CHECK: begin
            priority if (cell_hit[STACK_DEPTH-1]) begin
               status_in = lmba_pkg::ST_ALREADY;
               state_in  = lmba_pkg::S_RESPOND;
            end else if (size_ff >= cap_ff) begin
               status_in = lmba_pkg::ST_TOO_LARGE;
               state_in  = lmba_pkg::S_RESPOND;
            end else begin
               state_in = lmba_pkg::S_EVICT;
            end
         end
         lmba_pkg::S_EVICT: begin
            priority if (count_ff != '0 && demand >= {1'b0, cap_ff}) begin
               shift.pop  = 1'b1;
               used_in    = (used_ff >= top_size) ? used_ff - top_size : '0;
               count_in   = count_ff - 1'b1;
               evicted_in = evicted_ff + 1'b1;
            end else if (count_ff >= CNT_W'(STACK_DEPTH)) begin
               status_in  = lmba_pkg::ST_FULL;
               evicted_in = '0;
               state_in   = lmba_pkg::S_RESPOND;
            end else begin
               shift.push = 1'b1;
               count_in   = count_ff + 1'b1;
               used_in    = used_base + size_ff;
               status_in  = lmba_pkg::ST_ADMITTED;
               state_in   = lmba_pkg::S_RESPOND;
            end
         end
         lmba_pkg::S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lmba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lmba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmba_pkg::S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= lmba_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   assign count_wide   = 32'(count_ff);
   assign evicted_wide = 32'(evicted_ff);

   always_ff @(posedge clock) begin
      wait_ff    <= wait_in;
      evicted_ff <= evicted_in;
      id_ff      <= id_in;
      size_ff    <= size_in;
      status_ff  <= status_in;
      if (load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_evicted_ff <= evicted_wide[lmba_pkg::OUT_CNT_W-1:0];
         rsp_entries_ff <= count_wide[lmba_pkg::OUT_CNT_W-1:0];
         rsp_used_ff    <= used_ff;
         rsp_avail_ff   <= (cap_ff > used_ff) ? cap_ff - used_ff : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_evicted_count   = rsp_evicted_ff;
   assign rsp_used_after      = rsp_used_ff;
   assign rsp_available_after = rsp_avail_ff;
   assign rsp_entries_after   = rsp_entries_ff;

endmodule

[design/lmba_checker.sv]
// port-level checks for the lifo budget admission block, bound to the top
// depends on lmba_pkg and lifo_memory_budget_admission_macros.svh
`include "lifo_memory_budget_admission_macros.svh"

module lmba_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [1:0]                            rsp_status,
   input logic [lmba_pkg::OUT_CNT_W-1:0]        rsp_evicted_count,
   input logic [lmba_pkg::SIZE_W-1:0]           rsp_used_after,
   input logic [lmba_pkg::SIZE_W-1:0]           rsp_available_after,
   input logic [lmba_pkg::OUT_CNT_W-1:0]        rsp_entries_after
);

   logic rsp_stall;
   logic rsp_rejected;
   logic [2*lmba_pkg::SIZE_W+2*lmba_pkg::OUT_CNT_W+1:0] rsp_payload;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_rejected = rsp_valid && (rsp_status != lmba_pkg::ST_ADMITTED);
   assign rsp_payload  = {rsp_status, rsp_evicted_count, rsp_used_after,
                          rsp_available_after, rsp_entries_after};

   // a stalled result holds its payload
   `LMBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // only an admitted transaction evicts anything
   `LMBA_ASSERT_IMPLY(a_no_evict_on_reject, clock, reset, rsp_rejected, rsp_evicted_count == '0)

   // one transaction in flight: ready drops straight after an acceptance
   `LMBA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // nothing is offered right after reset
   `LMBA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind lifo_memory_budget_admission lmba_checker u_lmba_checker (.*);

[tb/tb.sv]
// self-checking testbench for lifo_memory_budget_admission: directed and random open requests
// against a predictor of the resident stack, with random stalls on both channels
// depends on lmba_pkg and the lifo_memory_budget_admission top level
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ID_W        = lmba_pkg::ID_W;
   localparam int unsigned SIZE_W      = lmba_pkg::SIZE_W;
   localparam int unsigned OUT_CNT_W   = lmba_pkg::OUT_CNT_W;
   localparam int unsigned STACK_DEPTH = 16;
   localparam int unsigned SETTLE      = 2 * STACK_DEPTH + 8;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASES      = 10;
   localparam int unsigned PHASE_ITEMS = 50;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } open_req_type;

   typedef struct {
      lmba_pkg::status_type status;
      logic [OUT_CNT_W-1:0] evicted;
      logic [SIZE_W-1:0]    used;
      logic [SIZE_W-1:0]    avail;
      logic [OUT_CNT_W-1:0] entries;
   } admission_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ID_W-1:0]      req_app_id = '0;
   logic [SIZE_W-1:0]    req_app_size = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [OUT_CNT_W-1:0] rsp_evicted_count;
   logic [SIZE_W-1:0]    rsp_used_after;
   logic [SIZE_W-1:0]    rsp_available_after;
   logic [OUT_CNT_W-1:0] rsp_entries_after;
   logic                 csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]    csr_wr_data = '0;

   // resident stack as the testbench sees it
   logic [ID_W-1:0]   res_ids [STACK_DEPTH];
   logic [SIZE_W-1:0] res_sizes [STACK_DEPTH];
   int unsigned       res_count = 0;
   int unsigned       res_used = 0;
   int unsigned       budget = lmba_pkg::CAPACITY_RESET;

   open_req_type  open_q[$];
   admission_type expected_q[$];
   open_req_type  drive_req;

   logic        req_done = 1'b0;
   bit          no_idle = 1'b0;
   int unsigned hold_asked = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_cnt = 0;
   int unsigned mismatches = 0;
   int unsigned accepted = 0;
   int unsigned results = 0;
   int unsigned budgets_written = 0;
   int unsigned status_hits [4];

   lifo_memory_budget_admission #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_app_id          (req_app_id),
      .req_app_size        (req_app_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_evicted_count   (rsp_evicted_count),
      .rsp_used_after      (rsp_used_after),
      .rsp_available_after (rsp_available_after),
      .rsp_entries_after   (rsp_entries_after),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic admission_type admit_request(input logic [ID_W-1:0] id,
                                                   input logic [SIZE_W-1:0] size);
      admission_type r;
      int unsigned   evicted;
      int unsigned   avail;
      bit            hit;
      evicted = 0;
      hit = 1'b0;
      for (int k = 0; k < res_count; k++)
         if (res_ids[k] == id) hit = 1'b1;
      if (hit) begin
         r.status = lmba_pkg::ST_ALREADY;
      end else if (size >= budget) begin
         r.status = lmba_pkg::ST_TOO_LARGE;
      end else begin
         // pop from the top until the new entry fits under the budget
         while (res_count > 0 && res_used + size >= budget) begin
            res_used = (res_used >= res_sizes[res_count-1]) ?
                       res_used - res_sizes[res_count-1] : 0;
            res_count--;
            evicted++;
         end
         if (res_count == 0) res_used = 0;
         if (res_count >= STACK_DEPTH) begin
            r.status = lmba_pkg::ST_FULL;
         end else begin
            res_ids[res_count] = id;
            res_sizes[res_count] = size;
            res_count++;
            res_used = (res_used + size) & 16'hFFFF;
            r.status = lmba_pkg::ST_ADMITTED;
         end
      end
      avail     = (budget > res_used) ? budget - res_used : 0;
      r.evicted = (r.status == lmba_pkg::ST_ADMITTED) ? evicted[OUT_CNT_W-1:0] : '0;
      r.used    = res_used[SIZE_W-1:0];
      r.avail   = avail[SIZE_W-1:0];
      r.entries = res_count[OUT_CNT_W-1:0];
      return r;
   endfunction

   // driver: the next transaction can go out at the falling edge after acceptance, or later when an idle gap is drawn
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (open_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
            drive_req = open_q.pop_front();
            req_valid <= 1'b1;
            req_app_id <= drive_req.id;
            req_app_size <= drive_req.size;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with a long hold-off whenever one is asked for
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
   end

   // monitor: both channels and the register port
   always @(posedge clock) begin
      admission_type exp;
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_valid && req_ready;
         if (csr_wr_en) budget = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            results++;
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("tb: result with nothing outstanding: st=%0d ev=%0d used=%0d",
                           rsp_status, rsp_evicted_count, rsp_used_after);
               mismatches++;
            end else begin
               exp = expected_q.pop_front();
               status_hits[exp.status]++;
               if (rsp_status !== exp.status || rsp_evicted_count !== exp.evicted ||
                   rsp_used_after !== exp.used || rsp_available_after !== exp.avail ||
                   rsp_entries_after !== exp.entries) begin
                  if (mismatches < 10)
                     $display({"tb: mismatch exp st=%0d ev=%0d used=%0d avail=%0d n=%0d",
                               " got %0d %0d %0d %0d %0d"},
                              exp.status, exp.evicted, exp.used, exp.avail, exp.entries,
                              rsp_status, rsp_evicted_count, rsp_used_after,
                              rsp_available_after, rsp_entries_after);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            accepted++;
            expected_q.push_back(admit_request(req_app_id, req_app_size));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic queue_open(input int unsigned id, input int unsigned size);
      open_req_type r;
      r.id = id[ID_W-1:0];
      r.size = size[SIZE_W-1:0];
      open_q.push_back(r);
   endtask

   task automatic drain();
      while (open_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_budget(input int unsigned value);
      drain();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[SIZE_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      budgets_written++;
   endtask

   initial begin
      int unsigned cap;
      int unsigned id;
      int unsigned size;
      int unsigned mode;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: admit, already open, too large, eviction, stack full
      queue_open(0, 0);
      queue_open(0, 5);
      queue_open(255, 199);
      queue_open(1, 65535);
      queue_open(3, 1);
      for (int k = 0; k < STACK_DEPTH - 2; k++) queue_open(10 + k, 1);
      queue_open(50, 1);
      queue_open(0, 9);
      // budget dropped under the resident total
      write_budget(5);
      queue_open(60, 0);
      // zero budget rejects everything not resident
      write_budget(0);
      queue_open(61, 0);
      queue_open(60, 0);
      write_budget(65535);
      queue_open(62, 65534);
      queue_open(63, 0);
      queue_open(64, 1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cap = 65535;
            1: cap = 1;
            2: cap = lmba_pkg::CAPACITY_RESET;
            5: cap = $urandom_range(1, 65535);
            default: cap = $urandom_range(16, 2000);
         endcase
         write_budget(cap);
         no_idle = (p == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            id = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 23);
            mode = $urandom_range(0, 7);
            case (mode)
               0, 1, 2, 3: size = $urandom_range(0, cap / 10);
               4: size = 0;
               5: size = $urandom_range(cap / 2, cap);
               6: size = $urandom_range(0, 65535);
               default: size = $urandom_range(0, cap / 3);
            endcase
            queue_open(id, size);
         end
         // receiver stalls while the sender keeps offering
         if (p == 6) hold_asked++;
      end
      drain();
      no_idle = 1'b0;
      repeat (SETTLE) @(posedge clock);
      if (expected_q.size() > 0) begin
         $display("tb: %0d results never arrived", expected_q.size());
         mismatches += expected_q.size();
      end

      $display("tb: %0d requests, %0d results over %0d budget settings",
               accepted, results, budgets_written + 1);
      $display("tb: %0d admitted, %0d already open, %0d too large, %0d stack full",
               status_hits[lmba_pkg::ST_ADMITTED], status_hits[lmba_pkg::ST_ALREADY],
               status_hits[lmba_pkg::ST_TOO_LARGE], status_hits[lmba_pkg::ST_FULL]);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
